/* src/mavrm_pkg.sv */
// ----------------------------------------------------------------------------
// Moving average then running median: shared definitions
// Default sizes, the sequencer state type and the cell operation codes.
// ----------------------------------------------------------------------------
`default_nettype none

package mavrm_pkg;

	// Default sizes of the two windows and of a sample.
	localparam int AVERAGE_DEPTH_DEF = 8;
	localparam int MEDIAN_DEPTH_DEF  = 100;
	localparam int SAMPLE_BITS_DEF   = 24;

	// Width of the filtered result on the output stream.
	localparam int FILTERED_BITS = 24;

	// Sequencer states of the top level.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOAD,
		ST_DIV,
		ST_DEL,
		ST_INS,
		ST_WAIT,
		ST_ROT
	} state_t;

	// Operation broadcast to every cell of the sorted chain.
	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_DEL,
		CELL_INS,
		CELL_ROT
	} cell_op_t;

endpackage

`default_nettype wire

/* src/mavrm_cell.sv */
// ----------------------------------------------------------------------------
// Sorted chain cell
// Holds one mean of the median window and moves it to or from its neighbors
// for delete, insert and rotate operations.
// ----------------------------------------------------------------------------
`default_nettype none

module mavrm_cell #(
	parameter int VALUE_BITS = mavrm_pkg::SAMPLE_BITS_DEF
) (
	input  wire                      clk,
	input  wire                      arst_n,
	input  mavrm_pkg::cell_op_t      op,
	input  wire  [VALUE_BITS-1:0]    key,
	input  wire                      prev_ge,
	input  wire  [VALUE_BITS-1:0]    lo_value,
	input  wire                      lo_valid,
	input  wire  [VALUE_BITS-1:0]    hi_value,
	input  wire                      hi_valid,
	output logic [VALUE_BITS-1:0]    value,
	output logic                     valid,
	output logic                     ge
);

	import mavrm_pkg::*;

	logic [VALUE_BITS-1:0] value_q;
	logic                  valid_q;
	logic [VALUE_BITS-1:0] value_d;
	logic                  valid_d;

	// An empty cell ranks above every key.
	assign ge    = !valid_q || (value_q >= key);
	assign value = value_q;
	assign valid = valid_q;

	// Next content: keep, take the upper neighbor, the lower neighbor or the key.
	always_comb begin
		value_d = value_q;
		valid_d = valid_q;
		unique case (op)
			CELL_HOLD: begin
				value_d = value_q;
				valid_d = valid_q;
			end
			CELL_DEL: begin
				if (ge) begin
					value_d = hi_value;
					valid_d = hi_valid;
				end
			end
			CELL_INS: begin
				if (ge && prev_ge) begin
					value_d = lo_value;
					valid_d = lo_valid;
				end else if (ge) begin
					value_d = key;
					valid_d = 1'b1;
				end
			end
			CELL_ROT: begin
				value_d = hi_value;
				valid_d = hi_valid;
			end
			default: begin
				value_d = value_q;
				valid_d = valid_q;
			end
		endcase
	end

	// The valid flag is control state and clears at reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= valid_d;
		end
	end

	// The value itself needs no reset.
	always_ff @(posedge clk) begin
		value_q <= value_d;
	end

endmodule

`default_nettype wire

/* src/mavrm_divider.sv */
// ----------------------------------------------------------------------------
// Restoring divider
// Divides the window sum by the fill count, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module mavrm_divider #(
	parameter int NUM_BITS = 27,
	parameter int DEN_BITS = 4
) (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   start,
	input  wire  [NUM_BITS-1:0]   dividend,
	input  wire  [DEN_BITS-1:0]   divisor,
	output logic                  done,
	output logic [NUM_BITS-1:0]   quotient
);

	import mavrm_pkg::*;

	localparam int CNT_BITS = $clog2(NUM_BITS);

	logic [NUM_BITS-1:0] quo_q;
	logic [DEN_BITS-1:0] rem_q;
	logic [DEN_BITS-1:0] den_q;
	logic [CNT_BITS-1:0] cnt_q;
	logic                busy_q;
	logic                done_q;
	logic [DEN_BITS:0]   rem_sh;
	logic [DEN_BITS:0]   rem_sub;
	logic                take;

	// One trial subtraction of the shifted remainder.
	assign rem_sh  = {rem_q, quo_q[NUM_BITS-1]};
	assign take    = rem_sh >= {1'b0, den_q};
	assign rem_sub = rem_sh - {1'b0, den_q};

	assign done     = done_q;
	assign quotient = quo_q;

	// Iteration control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				if (cnt_q == CNT_BITS'(NUM_BITS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q + 1'b1;
				end
			end
		end
	end

	// Quotient and remainder datapath.
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			den_q <= divisor;
		end else if (busy_q) begin
			if (take) begin
				rem_q <= rem_sub[DEN_BITS-1:0];
			end else begin
				rem_q <= rem_sh[DEN_BITS-1:0];
			end
			quo_q <= {quo_q[NUM_BITS-2:0], take};
		end
	end

endmodule

`default_nettype wire

/* src/moving_average_then_running_median_core.sv */
// ----------------------------------------------------------------------------
// Moving average then running median
// Frame interval smoother: the mean of the last samples feeds a sliding
// window whose median is returned for every sample.
//
//   Channel  Dir  Bits                     Content
//   s_*      in   tdata[SAMPLE_BITS-1:0]   sample (byte padded)
//   m_*      out  tdata[23:0]              filtered
//
// Each sample runs through the bit-serial divider, then a delete step once the
// median window is full, an insert step and one full rotation of the sorted
// cell chain.
// Reset clears the fill counts and the cell valid flags; no sweep is needed.
// A waiting result holds the sequencer before the rotation, and the next
// sample is accepted only after the rotation has finished.
// ----------------------------------------------------------------------------
`default_nettype none

module moving_average_then_running_median_core #(
	parameter int AVERAGE_DEPTH = mavrm_pkg::AVERAGE_DEPTH_DEF,
	parameter int MEDIAN_DEPTH  = mavrm_pkg::MEDIAN_DEPTH_DEF,
	parameter int SAMPLE_BITS   = mavrm_pkg::SAMPLE_BITS_DEF
) (
	input  wire                                    clk,
	input  wire                                    arst_n,
	input  wire                                    s_tvalid,
	output logic                                   s_tready,
	// Fields from bit 0: sample, then zero padding.
	input  wire  [((SAMPLE_BITS+7)/8)*8-1:0]       s_tdata,
	output logic                                   m_tvalid,
	input  wire                                    m_tready,
	// Fields from bit 0: filtered.
	output logic [mavrm_pkg::FILTERED_BITS-1:0]    m_tdata
);

	import mavrm_pkg::*;

	localparam int AFW   = $clog2(AVERAGE_DEPTH + 1);
	localparam int SUMB  = SAMPLE_BITS + $clog2(AVERAGE_DEPTH);
	localparam int MSW   = $clog2(MEDIAN_DEPTH);
	localparam int MFW   = $clog2(MEDIAN_DEPTH + 1);
	localparam int WIDEB = (SAMPLE_BITS > FILTERED_BITS) ? SAMPLE_BITS : FILTERED_BITS;

	state_t state_q;
	state_t state_d;

	logic [SAMPLE_BITS-1:0]   sample_q;
	logic [SAMPLE_BITS-1:0]   avg_tap_q [AVERAGE_DEPTH];
	logic [AFW-1:0]           avg_fill_q;
	logic [AFW-1:0]           avg_fill_d;
	logic [SUMB-1:0]          avg_sum_q;
	logic [SUMB-1:0]          avg_sum_d;
	logic                     avg_full;

	logic                     div_done;
	logic [SUMB-1:0]          div_quo;
	logic [SAMPLE_BITS-1:0]   mean;

	logic [SAMPLE_BITS-1:0]   mean_mem [MEDIAN_DEPTH];
	logic [SAMPLE_BITS-1:0]   oldest_q;
	logic [MSW-1:0]           med_slot_q;
	logic [MFW-1:0]           med_fill_q;
	logic                     med_full;
	logic [MFW-1:0]           rank;
	logic [MSW-1:0]           rot_q;
	logic                     rot_last;
	logic                     capture;

	cell_op_t                 cell_op;
	logic [SAMPLE_BITS-1:0]   cell_key;
	logic [SAMPLE_BITS-1:0]   cell_value [MEDIAN_DEPTH];
	logic [MEDIAN_DEPTH-1:0]  cell_valid;
	logic [MEDIAN_DEPTH-1:0]  cell_ge;
	logic [SAMPLE_BITS-1:0]   top_hi_value;
	logic                     top_hi_valid;
	logic [WIDEB-1:0]         head_wide;

	logic                     m_tvalid_q;
	logic [FILTERED_BITS-1:0] m_tdata_q;

	assign avg_full = (avg_fill_q == AFW'(AVERAGE_DEPTH));
	assign med_full = (med_fill_q == MFW'(MEDIAN_DEPTH));
	assign rank     = med_fill_q >> 1;
	assign rot_last = (rot_q == MSW'(MEDIAN_DEPTH - 1));
	assign capture  = (state_q == ST_ROT) && (MFW'(rot_q) == rank);
	assign mean     = div_quo[SAMPLE_BITS-1:0];

	// Running window sum: add the new sample, drop the one that falls out.
	always_comb begin
		avg_sum_d = avg_sum_q + SUMB'(sample_q);
		if (avg_full) begin
			avg_sum_d = avg_sum_d - SUMB'(avg_tap_q[AVERAGE_DEPTH-1]);
		end
		avg_fill_d = avg_full ? avg_fill_q : avg_fill_q + 1'b1;
	end

	// Next state of the sequencer.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (s_tvalid) state_d = ST_LOAD;
			ST_LOAD: state_d = ST_DIV;
			ST_DIV:  if (div_done) state_d = med_full ? ST_DEL : ST_INS;
			ST_DEL:  state_d = ST_INS;
			ST_INS:  state_d = ST_WAIT;
			ST_WAIT: if (!m_tvalid_q) state_d = ST_ROT;
			ST_ROT:  if (rot_last) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// Sequencer outputs: handshake and the operation for the cell chain.
	always_comb begin
		s_tready = 1'b0;
		cell_op  = CELL_HOLD;
		cell_key = mean;
		unique case (state_q)
			ST_IDLE: s_tready = 1'b1;
			ST_DEL: begin
				cell_op  = CELL_DEL;
				cell_key = oldest_q;
			end
			ST_INS:  cell_op = CELL_INS;
			ST_ROT:  cell_op = CELL_ROT;
			default: cell_op = CELL_HOLD;
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			avg_fill_q <= '0;
			avg_sum_q  <= '0;
			med_fill_q <= '0;
			med_slot_q <= '0;
			rot_q      <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_LOAD) begin
				avg_fill_q <= avg_fill_d;
				avg_sum_q  <= avg_sum_d;
			end
			if (state_q == ST_INS) begin
				if (!med_full) begin
					med_fill_q <= med_fill_q + 1'b1;
				end
				med_slot_q <= (med_slot_q == MSW'(MEDIAN_DEPTH - 1)) ? '0 : med_slot_q + 1'b1;
			end
			if (state_q == ST_ROT) begin
				rot_q <= rot_last ? '0 : rot_q + 1'b1;
			end
			if (capture) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// Sample register and the averaging shift line.
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			sample_q <= s_tdata[SAMPLE_BITS-1:0];
		end
		if (state_q == ST_LOAD) begin
			avg_tap_q[0] <= sample_q;
			for (int k = 1; k < AVERAGE_DEPTH; k++) begin
				avg_tap_q[k] <= avg_tap_q[k-1];
			end
		end
	end

	// History of means: the oldest is read before the new mean overwrites it.
	always_ff @(posedge clk) begin
		if (state_q == ST_LOAD) begin
			oldest_q <= mean_mem[med_slot_q];
		end
		if (state_q == ST_INS) begin
			mean_mem[med_slot_q] <= mean;
		end
	end

	// Result register, loaded from the head cell during the rotation.
	assign head_wide = WIDEB'(cell_value[0]);

	always_ff @(posedge clk) begin
		if (capture) begin
			m_tdata_q <= head_wide[FILTERED_BITS-1:0];
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	// Window mean: sum divided by the current fill count.
	mavrm_divider #(
		.NUM_BITS (SUMB),
		.DEN_BITS (AFW)
	) u_divider (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (state_q == ST_LOAD),
		.dividend (avg_sum_d),
		.divisor  (avg_fill_d),
		.done     (div_done),
		.quotient (div_quo)
	);

	// The last cell wraps to the head on rotation and takes an empty entry on delete.
	assign top_hi_value = cell_value[0];
	assign top_hi_valid = (cell_op == CELL_ROT) ? cell_valid[0] : 1'b0;

	// Sorted chain of cells, ascending from the head.
	for (genvar k = 0; k < MEDIAN_DEPTH; k++) begin : g_cell
		logic [SAMPLE_BITS-1:0] lo_value;
		logic                   lo_valid;
		logic                   prev_ge;
		logic [SAMPLE_BITS-1:0] hi_value;
		logic                   hi_valid;

		if (k == 0) begin : g_head
			assign lo_value = '0;
			assign lo_valid = 1'b0;
			assign prev_ge  = 1'b0;
		end else begin : g_body
			assign lo_value = cell_value[k-1];
			assign lo_valid = cell_valid[k-1];
			assign prev_ge  = cell_ge[k-1];
		end

		if (k == MEDIAN_DEPTH - 1) begin : g_tail
			assign hi_value = top_hi_value;
			assign hi_valid = top_hi_valid;
		end else begin : g_next
			assign hi_value = cell_value[k+1];
			assign hi_valid = cell_valid[k+1];
		end

		mavrm_cell #(
			.VALUE_BITS (SAMPLE_BITS)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.op       (cell_op),
			.key      (cell_key),
			.prev_ge  (prev_ge),
			.lo_value (lo_value),
			.lo_valid (lo_valid),
			.hi_value (hi_value),
			.hi_valid (hi_valid),
			.value    (cell_value[k]),
			.valid    (cell_valid[k]),
			.ge       (cell_ge[k])
		);
	end

`ifndef SYNTHESIS
	logic [MEDIAN_DEPTH-2:0] order_ok;

	for (genvar k = 0; k < MEDIAN_DEPTH - 1; k++) begin : g_order
		assign order_ok[k] = !cell_valid[k+1] ||
			(cell_valid[k] && (cell_value[k] <= cell_value[k+1]));
	end

	// Between samples the chain is sorted and its filled cells are contiguous.
	a_chain_sorted: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> (&order_ok))
		else $error("median chain out of order while idle");

	// Between samples the number of filled cells matches the median fill count.
	a_chain_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> ($countones(cell_valid) == 32'(med_fill_q)))
		else $error("median chain count differs from fill count");

	// A quotient is finished only while the sequencer waits for it.
	a_div_done: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == ST_DIV))
		else $error("divider finished outside the divide step");

	// A result is loaded only into an empty output register.
	a_capture_free: assert property (@(posedge clk) disable iff (!arst_n)
		capture |-> !m_tvalid_q)
		else $error("result captured over a pending result");
`endif

endmodule

`default_nettype wire
